// ===== rtl/ldnw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD decimal number writer package
// Shared widths, constants and request/response types.
// ----------------------------------------------------------------------------
package ldnw_pkg;

   localparam int VALUE_W     = 32;
   localparam int COLUMN_W    = 6;
   localparam int FULL_DIGITS = 10;
   localparam int MAX_DIGITS  = 10;
   localparam int DIGIT_W     = 4;
   localparam int DIGIT_IDX_W = $clog2(FULL_DIGITS);
   localparam int STEP_W      = $clog2(VALUE_W);
   localparam int KEEP_DIGITS = (MAX_DIGITS < FULL_DIGITS) ? MAX_DIGITS : FULL_DIGITS;

   localparam logic [DIGIT_IDX_W-1:0] TOP_DIGIT  = DIGIT_IDX_W'(KEEP_DIGITS - 1);
   localparam logic [STEP_W-1:0]      LAST_STEP  = STEP_W'(VALUE_W - 1);
   localparam logic [7:0]             CMD_SET_ADDR = 8'h80;
   localparam logic [6:0]             ROW_STRIDE   = 7'h40;
   localparam logic [7:0]             ASCII_ZERO   = 8'h30;
   localparam logic [DIGIT_W-1:0]     DIGIT_FIX_MIN = 4'd5;
   localparam logic [DIGIT_W-1:0]     DIGIT_FIX_ADD = 4'd3;
   localparam logic [DIGIT_W-1:0]     DIGIT_MAX     = 4'd9;

   typedef logic [FULL_DIGITS-1:0][DIGIT_W-1:0] bcd_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  value;
      logic [COLUMN_W-1:0] column;
      logic                row;
   } req_type;

   typedef struct packed {
      logic       is_data;
      logic [7:0] lcd_byte;
      logic       last;
   } rsp_type;

endpackage

// ===== rtl/ldnw_bcd_conv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD decimal number writer: binary to BCD converter
// Shift-and-add-3 unit, one input bit per cycle, done pulse after the last.
// ----------------------------------------------------------------------------
module ldnw_bcd_conv (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic [ldnw_pkg::VALUE_W-1:0]  value,
   output logic                          done,
   output ldnw_pkg::bcd_type             digits
);
   import ldnw_pkg::*;

   logic [VALUE_W-1:0] shift_ff, shift_in;
   bcd_type            bcd_ff, bcd_in;
   bcd_type            bcd_fix;
   logic [FULL_DIGITS*DIGIT_W-1:0] fix_flat;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic               run_ff, run_in;
   logic               done_ff, done_in;

   // Each digit of five or more is bumped by three before the shift.
   always_comb begin
      for (int d = 0; d < FULL_DIGITS; d++) begin
         if (bcd_ff[d] >= DIGIT_FIX_MIN) begin
            bcd_fix[d] = bcd_ff[d] + DIGIT_FIX_ADD;
         end else begin
            bcd_fix[d] = bcd_ff[d];
         end
      end
   end

   assign fix_flat = bcd_fix;

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      step_in  = step_ff;
      run_in   = run_ff;
      done_in  = 1'b0;
      if (load) begin
         shift_in = value;
         bcd_in   = '0;
         step_in  = '0;
         run_in   = 1'b1;
      end else if (run_ff) begin
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {fix_flat[FULL_DIGITS*DIGIT_W-2:0], shift_ff[VALUE_W-1]};
         step_in  = step_ff + 1'b1;
         if (step_ff == LAST_STEP) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      step_ff  <= step_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

// ===== rtl/lcd_decimal_number_writer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD decimal number writer
// Emits a set-address command, then the value's decimal digits in ASCII.
// ----------------------------------------------------------------------------
// The command byte is registered and appears in the cycle after the request is taken.
// The shift-and-add-3 converter works through every value bit, then a scan
// skips leading zeros and digits go out one per cycle; busy stays high until
// the last digit is sent, and a new request is taken only while idle.
// Results cannot be stalled. Synchronous reset returns the sequencer to idle,
// clears the strobe and stops the converter; other registers are not cleared.
module lcd_decimal_number_writer_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ldnw_pkg::req_type req_data,
   output logic              rsp_valid,
   output ldnw_pkg::rsp_type rsp_data
);
   import ldnw_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_CONV = 4'b0010,
      ST_SCAN = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [DIGIT_IDX_W-1:0]  idx_ff, idx_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    accept;
   logic                    conv_done;
   bcd_type                 digits;
   logic [DIGIT_W-1:0]      cur_digit;
   logic [6:0]              address;
   logic                    upper_nonzero;

   assign accept    = start && (state_ff == ST_IDLE);
   assign cur_digit = digits[idx_ff];
   assign address   = {1'b0, req_data.column} + (req_data.row ? ROW_STRIDE : 7'd0);

   // When digits above the kept ones are set, the kept digits all go out,
   // zeros included.
   always_comb begin
      upper_nonzero = 1'b0;
      for (int d = KEEP_DIGITS; d < FULL_DIGITS; d++) begin
         if (digits[d] != '0) begin
            upper_nonzero = 1'b1;
         end
      end
   end

   ldnw_bcd_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .load   (accept),
      .value  (req_data.value),
      .done   (conv_done),
      .digits (digits)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in    = 1'b1;
               rsp_in.is_data  = 1'b0;
               rsp_in.lcd_byte = CMD_SET_ADDR | {1'b0, address};
               rsp_in.last     = 1'b0;
               state_in        = ST_CONV;
            end
         end
         ST_CONV: begin
            if (conv_done) begin
               idx_in   = TOP_DIGIT;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // The lowest digit is always shown, so zero still prints '0'.
            if (!upper_nonzero && cur_digit == '0 && idx_ff != '0) begin
               idx_in = idx_ff - 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            rsp_valid_in    = 1'b1;
            rsp_in.is_data  = 1'b1;
            rsp_in.lcd_byte = ASCII_ZERO | {4'd0, cur_digit};
            rsp_in.last     = (idx_ff == '0);
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff - 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_cmd_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid && !rsp_data.is_data && !rsp_data.last && busy)
      else $error("command byte did not follow an accepted request");

   a_last_is_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.is_data && !busy)
      else $error("last flag on a command byte or while still busy");

   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_data |->
         rsp_data.lcd_byte >= ASCII_ZERO && rsp_data.lcd_byte <= (ASCII_ZERO + 8'(DIGIT_MAX)))
      else $error("data byte is not an ASCII digit");

   a_done_in_conv: assert property (@(posedge clock) disable iff (reset)
      conv_done |-> state_ff == ST_CONV)
      else $error("converter finished outside the conversion state");

   a_no_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> busy)
      else $error("response strobe while idle without last flag");

endmodule
